>>> sv/swc2d_pkg.sv
// Shared types and constants for the sliding-window 2D convolution block.
// No dependencies; imported by every module of the block.
`default_nettype none

package swc2d_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 8;
    localparam int PROD_W     = 17;   // unsigned 8 x signed 8
    localparam int VAL_W      = 21;   // sums wrap modulo 2^21
    localparam int ROW_W      = 16;
    localparam int OCOL_W     = 10;
    localparam int CIDX_W     = 5;
    localparam int IW_W       = 11;
    localparam int IH_W       = 16;
    localparam int KS_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [IW_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [IH_W-1:0] IMAGE_HEIGHT_RST = 16'd1024;
    localparam logic [KS_W-1:0] KERNEL_SIZE_RST  = 3'd3;

    localparam logic KIND_COEF  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_KERNEL_SIZE  = 2'd2
    } t_cfg_index;

    // per-cell controls
    typedef struct packed {
        logic shift;     // pixel transfer: window moves one column
        logic load_col;  // take the incoming column instead of the east neighbour
        logic coef_we;   // coefficient transfer addressed to this cell
        logic mult_en;   // product stage may load
        logic active;    // cell lies inside the kernel in use
    } t_cell_ctrl;

    typedef struct packed {
        logic row_en;
        logic total_en;
    } t_sum_ctrl;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic              last;
    } t_meta;

endpackage

`default_nettype wire

>>> sv/swc2d_cell.sv
// One window cell: pixel register, coefficient register and registered product.
// Depends on swc2d_pkg.
`default_nettype none

module swc2d_cell (
    input  wire                                   i_clk,
    input  swc2d_pkg::t_cell_ctrl                 i_ctrl,
    input  wire  [swc2d_pkg::PIX_W-1:0]           i_col_pix,
    input  wire  [swc2d_pkg::PIX_W-1:0]           i_east_pix,
    input  wire  signed [swc2d_pkg::COEF_W-1:0]   i_coef,
    output logic [swc2d_pkg::PIX_W-1:0]           o_pix,
    output logic signed [swc2d_pkg::PROD_W-1:0]   o_prod
);
    import swc2d_pkg::*;

    logic [PIX_W-1:0]         r_pix;
    logic signed [COEF_W-1:0] r_coef;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    always_comb begin
        n_prod = $signed({1'b0, r_pix}) * r_coef;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_pix <= i_ctrl.load_col ? i_col_pix : i_east_pix;
        end
        if (i_ctrl.coef_we) begin
            r_coef <= i_coef;
        end
        if (i_ctrl.mult_en) begin
            r_prod <= i_ctrl.active ? n_prod : '0;
        end
    end

    assign o_pix  = r_pix;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> sv/swc2d_linebuf.sv
// Line buffer: one word per image column holding the pixels of the rows above.
// Registered read with write-through when both ports hit the same column.
`default_nettype none

module swc2d_linebuf #(
    parameter int DEPTH  = 1024,
    parameter int WORD_W = 32
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire  [WORD_W-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WORD_W-1:0]         o_rdata
);
    import swc2d_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/swc2d_sum.sv
// Two-level registered adder tree: one sum per window row, then the total.
// Depends on swc2d_pkg.
`default_nettype none

module swc2d_sum #(
    parameter int MAX_KERNEL = 5
) (
    input  wire                                  i_clk,
    input  swc2d_pkg::t_sum_ctrl                 i_ctrl,
    input  wire  signed [swc2d_pkg::PROD_W-1:0]  i_prod [MAX_KERNEL][MAX_KERNEL],
    output logic signed [swc2d_pkg::VAL_W-1:0]   o_total
);
    import swc2d_pkg::*;

    logic signed [VAL_W-1:0] r_row_sum [MAX_KERNEL];
    logic signed [VAL_W-1:0] n_row_sum [MAX_KERNEL];
    logic signed [VAL_W-1:0] r_total;
    logic signed [VAL_W-1:0] n_total;

    always_comb begin
        for (int r = 0; r < MAX_KERNEL; r++) begin
            n_row_sum[r] = '0;
            for (int c = 0; c < MAX_KERNEL; c++) begin
                n_row_sum[r] = n_row_sum[r] + VAL_W'(i_prod[r][c]);
            end
        end
    end

    always_comb begin
        n_total = '0;
        for (int r = 0; r < MAX_KERNEL; r++) begin
            n_total = n_total + r_row_sum[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.row_en) begin
            r_row_sum <= n_row_sum;
        end
        if (i_ctrl.total_en) begin
            r_total <= n_total;
        end
    end

    assign o_total = r_total;

endmodule

`default_nettype wire

>>> sv/sliding_window_convolution_2d.sv
// Sliding-window 2D convolution (valid region), square kernel up to MAX_KERNEL.
// Throughput: one transfer per cycle, pixels and coefficients alike, until
// back-pressure fills every stage. A pixel whose window completes shows its
// result once products, row sums and total are registered.
// Reset: counters to zero, registers to their defaults; kernel and line buffer
// contents are not cleared and hold whatever was last written.
`default_nettype none

module sliding_window_convolution_2d #(
    parameter int MAX_KERNEL = 5,
    parameter int MAX_WIDTH  = 1024
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // configuration
    input  wire                                   i_cfg_we,
    input  wire  [swc2d_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [swc2d_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input channel
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire                                   i_kind,
    input  wire  [swc2d_pkg::CIDX_W-1:0]          i_coef_index,
    input  wire  signed [swc2d_pkg::COEF_W-1:0]   i_coef_value,
    input  wire  [swc2d_pkg::PIX_W-1:0]           i_pixel,
    // output channel
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic signed [swc2d_pkg::VAL_W-1:0]    o_value,
    output logic [swc2d_pkg::ROW_W-1:0]           o_out_row,
    output logic [swc2d_pkg::OCOL_W-1:0]          o_out_col,
    output logic                                  o_last_of_image
);
    import swc2d_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int KW  = $clog2(MAX_KERNEL + 1);
    // rows kept in the line buffer above the incoming one
    localparam int STK = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;

    // ------------------------------------------------------------------
    // Configuration registers and their effective (saturated) values
    // ------------------------------------------------------------------
    logic [IW_W-1:0] r_cfg_width;
    logic [IH_W-1:0] r_cfg_height;
    logic [KS_W-1:0] r_cfg_ksize;
    logic            cfg_restart;

    logic [CW-1:0]    w_last;
    logic [ROW_W-1:0] h_last;
    logic [KW-1:0]    k_eff;
    logic [KW-1:0]    k_m1;

    always_comb begin
        cfg_restart = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH,
                CFG_IMAGE_HEIGHT,
                CFG_KERNEL_SIZE: cfg_restart = 1'b1;
                default:         cfg_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= IMAGE_WIDTH_RST;
            r_cfg_height <= IMAGE_HEIGHT_RST;
            r_cfg_ksize  <= KERNEL_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[IW_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[IH_W-1:0];
                CFG_KERNEL_SIZE:  r_cfg_ksize  <= i_cfg_data[KS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_width == '0) begin
            w_last = '0;
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(r_cfg_width - 11'd1);
        end

        h_last = (r_cfg_height == '0) ? '0 : r_cfg_height - 16'd1;

        if (r_cfg_ksize == '0) begin
            k_eff = KW'(1);
        end else if (32'(r_cfg_ksize) > 32'(MAX_KERNEL)) begin
            k_eff = KW'(MAX_KERNEL);
        end else begin
            k_eff = KW'(r_cfg_ksize);
        end
        k_m1 = k_eff - KW'(1);
    end

    // ------------------------------------------------------------------
    // Handshake and stage enables. Stage 1 is the window itself, stage 2
    // the products, stage 3 the row sums, stage 4 the output register.
    // Each stage loads when it is empty or its successor moves on, so
    // bubbles close up and a waiting result blocks transfers only once
    // every stage is full.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic en2, en3, en4;
    logic accept, pix_acc, coef_acc;
    logic produce;

    assign en4        = !r_v4 || i_out_ready;
    assign en3        = !r_v3 || en4;
    assign en2        = !r_v2 || en3;
    assign o_in_ready = !r_v1 || en2;

    assign accept   = i_in_valid && o_in_ready;
    assign pix_acc  = accept && (i_kind == KIND_PIXEL);
    assign coef_acc = accept && (i_kind == KIND_COEF);

    // ------------------------------------------------------------------
    // Raster position
    // ------------------------------------------------------------------
    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (!i_rst_n || cfg_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (pix_acc) begin
            if (r_col == w_last) begin
                n_col = '0;
                n_row = (r_row == h_last) ? '0 : r_row + 16'd1;
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
        r_row <= n_row;
    end

    // window complete once k rows and k columns have arrived
    assign produce = (32'(r_row) >= 32'(k_m1)) && (32'(r_col) >= 32'(k_m1));

    // ------------------------------------------------------------------
    // Line buffer: word at a column = pixels of the rows above, nearest
    // first. Read address is the next column, so the registered word is
    // ready when the pixel of that column transfers.
    // ------------------------------------------------------------------
    logic [STK*PIX_W-1:0] lb_rdata;
    logic [STK*PIX_W-1:0] lb_wdata;
    logic [PIX_W-1:0]     colv [MAX_KERNEL];   // index = rows above current

    always_comb begin
        colv[0] = i_pixel;
        for (int j = 1; j < MAX_KERNEL; j++) begin
            colv[j] = lb_rdata[(j-1)*PIX_W +: PIX_W];
        end
        lb_wdata = '0;
        for (int e = 0; e < MAX_KERNEL - 1; e++) begin
            lb_wdata[e*PIX_W +: PIX_W] = colv[e];
        end
    end

    swc2d_linebuf #(
        .DEPTH  (MAX_WIDTH),
        .WORD_W (STK * PIX_W)
    ) u_linebuf (
        .i_clk   (i_clk),
        .i_we    (pix_acc),
        .i_waddr (r_col),
        .i_wdata (lb_wdata),
        .i_raddr (n_col),
        .o_rdata (lb_rdata)
    );

    // ------------------------------------------------------------------
    // Cell array. Cell (r,c) holds kernel word r*MAX_KERNEL+c and the pixel
    // lying r rows and c columns from the window's top-left corner. Column
    // k-1 takes the new column, the others take their east neighbour.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]         col_in   [MAX_KERNEL];
    logic [PIX_W-1:0]         cell_pix [MAX_KERNEL][MAX_KERNEL];
    logic signed [PROD_W-1:0] cell_prod[MAX_KERNEL][MAX_KERNEL];
    t_cell_ctrl               cell_ctrl[MAX_KERNEL][MAX_KERNEL];

    always_comb begin
        for (int r = 0; r < MAX_KERNEL; r++) begin
            col_in[r] = i_pixel;
            for (int j = 0; j < MAX_KERNEL; j++) begin
                if (j + r == 32'(k_m1)) begin
                    col_in[r] = colv[j];
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < MAX_KERNEL; r++) begin
            for (int c = 0; c < MAX_KERNEL; c++) begin
                cell_ctrl[r][c].shift    = pix_acc;
                cell_ctrl[r][c].load_col = (c == 32'(k_m1));
                cell_ctrl[r][c].coef_we  = coef_acc &&
                                           (32'(i_coef_index) == r * MAX_KERNEL + c);
                cell_ctrl[r][c].mult_en  = en2;
                cell_ctrl[r][c].active   = (r <= 32'(k_m1)) && (c <= 32'(k_m1));
            end
        end
    end

    for (genvar gr = 0; gr < MAX_KERNEL; gr++) begin : g_row
        for (genvar gc = 0; gc < MAX_KERNEL; gc++) begin : g_col
            logic [PIX_W-1:0] east;
            if (gc == MAX_KERNEL - 1) begin : g_edge
                assign east = col_in[gr];
            end else begin : g_inner
                assign east = cell_pix[gr][gc+1];
            end

            swc2d_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (cell_ctrl[gr][gc]),
                .i_col_pix  (col_in[gr]),
                .i_east_pix (east),
                .i_coef     (i_coef_value),
                .o_pix      (cell_pix[gr][gc]),
                .o_prod     (cell_prod[gr][gc])
            );
        end
    end

    // ------------------------------------------------------------------
    // Adder tree
    // ------------------------------------------------------------------
    t_sum_ctrl sum_ctrl;

    assign sum_ctrl.row_en   = en3;
    assign sum_ctrl.total_en = en4;

    swc2d_sum #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_sum (
        .i_clk   (i_clk),
        .i_ctrl  (sum_ctrl),
        .i_prod  (cell_prod),
        .o_total (o_value)
    );

    // ------------------------------------------------------------------
    // Valid bits and output position, carried alongside the data
    // ------------------------------------------------------------------
    t_meta         r_m1, r_m2, r_m3, r_m4;
    t_meta         n_m1;
    logic [CW-1:0] left;

    always_comb begin
        left      = r_col - CW'(k_m1);
        n_m1.row  = r_row - ROW_W'(k_m1);
        n_m1.col  = OCOL_W'(left);
        n_m1.last = (r_row == h_last) && (r_col == w_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_v1 <= pix_acc && produce;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_m1 <= n_m1;
        end
        if (en2) begin
            r_m2 <= r_m1;
        end
        if (en3) begin
            r_m3 <= r_m2;
        end
        if (en4) begin
            r_m4 <= r_m3;
        end
    end

    assign o_out_valid     = r_v4;
    assign o_out_row       = r_m4.row;
    assign o_out_col       = r_m4.col;
    assign o_last_of_image = r_m4.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // input only stalls with every stage full and the output held back
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && !i_out_ready))
        else $error("input stalled with room in the pipeline");

    // raster position stays inside the configured image
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= w_last) && (r_row <= h_last))
        else $error("raster position outside the image");

    // a coefficient transfer never starts a result
    a_coef_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        coef_acc |=> !r_v1)
        else $error("coefficient transfer produced a result");

endmodule

`default_nettype wire

>>> tb/sliding_window_convolution_2d_test.sv
// Self-checking bench for sliding_window_convolution_2d: a window-sum predictor in a small
// scoreboard class, valid/ready drivers with random idling, plain register writes.
// Depends on swc2d_pkg and the block itself; reads no files.
`default_nettype none

module sliding_window_convolution_2d_test;
    import swc2d_pkg::*;

    localparam int MAX_KERNEL    = 5;
    localparam int MAX_WIDTH     = 1024;
    localparam int KERNEL_TAPS   = MAX_KERNEL * MAX_KERNEL;
    localparam int STREAM_TARGET = 560;   // random items to offer
    localparam int STEADY_FROM   = 480;   // no idling from here on
    localparam int WIDE_PIXELS   = 64;    // pixels fed with the all-ones registers
    localparam int PRESSURE_PHASE = 2;    // phase with the long receiver hold-off
    localparam int UNUSED_REG_PHASE = 4;  // phase with a write to the unused index
    localparam int LONG_HOLD     = 80;    // cycles the receiver refuses results
    localparam int SETTLE        = 8;     // pipeline is 4 deep; the wait leaves room beyond that to be safe
    localparam int TAIL          = 20;
    localparam int STALL_LIMIT   = 2000;  // cycles with no transfer before giving up

    // index 3 of the register port maps to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic [ROW_W-1:0]        row;
        logic [OCOL_W-1:0]       col;
        logic                    last;
    } t_conv_result;

    // ------------------------------------------------------------------
    // Predictor: mirrors kernel store, line buffers and raster counters,
    // queues one expected sum per pixel whose window is complete.
    // ------------------------------------------------------------------
    class t_window_sum_board;
        logic [IW_W-1:0]         width_reg;
        logic [IH_W-1:0]         height_reg;
        logic [KS_W-1:0]         ksize_reg;
        logic signed [COEF_W-1:0] coef_mem [KERNEL_TAPS];
        logic [PIX_W-1:0]        lines [MAX_KERNEL][MAX_WIDTH];
        int unsigned             row_pos;
        int unsigned             col_pos;
        t_conv_result            pending_sums [$];
        int                      faults;

        function new();
            width_reg  = IMAGE_WIDTH_RST;
            height_reg = IMAGE_HEIGHT_RST;
            ksize_reg  = KERNEL_SIZE_RST;
            row_pos    = 0;
            col_pos    = 0;
            faults     = 0;
        endfunction

        function void flag(string what);
            faults++;
            if (faults <= 10) $display("%0t mismatch: %s", $time, what);
        endfunction

        function int outstanding();
            return pending_sums.size();
        endfunction

        // any real register write restarts the image; the kernel stays
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg  = data[IW_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg = data[IH_W-1:0];
                CFG_KERNEL_SIZE:  ksize_reg  = data[KS_W-1:0];
                default:          return;
            endcase
            row_pos = 0;
            col_pos = 0;
        endfunction

        function void take_item(logic kind, logic [CIDX_W-1:0] cidx,
                                logic signed [COEF_W-1:0] cval, logic [PIX_W-1:0] pix);
            int unsigned  wid, hgt, ks, top, left, r, c;
            int           acc;
            t_conv_result want;
            if (kind == KIND_COEF) begin
                if (cidx < KERNEL_TAPS) coef_mem[cidx] = cval;
                return;
            end
            // registers are used saturated to their legal ranges
            wid = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
            hgt = (height_reg == 0) ? 1 : height_reg;
            ks  = (ksize_reg == 0) ? 1 : (ksize_reg > MAX_KERNEL) ? MAX_KERNEL : ksize_reg;
            lines[row_pos % MAX_KERNEL][col_pos] = pix;
            if (row_pos + 1 >= ks && col_pos + 1 >= ks) begin
                top  = row_pos + 1 - ks;
                left = col_pos + 1 - ks;
                acc  = 0;
                for (r = 0; r < ks; r++) begin
                    for (c = 0; c < ks; c++) begin
                        acc += int'(lines[(top + r) % MAX_KERNEL][left + c])
                             * int'(coef_mem[r * MAX_KERNEL + c]);
                    end
                end
                want.value = acc[VAL_W-1:0];
                want.row   = top[ROW_W-1:0];
                want.col   = left[OCOL_W-1:0];
                want.last  = (row_pos + 1 == hgt) && (col_pos + 1 == wid);
                pending_sums.push_back(want);
            end
            col_pos++;
            if (col_pos >= wid) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= hgt) row_pos = 0;
            end
        endfunction

        function void match_result(t_conv_result got);
            t_conv_result want;
            if (pending_sums.size() == 0) begin
                flag($sformatf("unexpected result value=%0d row=%0d col=%0d last=%0b",
                               got.value, got.row, got.col, got.last));
                return;
            end
            want = pending_sums.pop_front();
            if (got.value !== want.value || got.row !== want.row ||
                got.col !== want.col || got.last !== want.last)
                flag($sformatf({"expected value=%0d row=%0d col=%0d last=%0b, ",
                                "got value=%0d row=%0d col=%0d last=%0b"},
                               want.value, want.row, want.col, want.last,
                               got.value, got.row, got.col, got.last));
        endfunction

        function void close_out();
            if (pending_sums.size() != 0)
                flag($sformatf("%0d results never arrived", pending_sums.size()));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block under test; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data   = '0;
    logic                    i_in_valid   = 1'b0;
    logic                    i_kind       = KIND_COEF;
    logic [CIDX_W-1:0]       i_coef_index = '0;
    logic [COEF_W-1:0]       i_coef_value = '0;
    logic [PIX_W-1:0]        i_pixel      = '0;
    logic                    i_out_ready  = 1'b0;
    wire                     o_in_ready;
    wire                     o_out_valid;
    wire signed [VAL_W-1:0]  o_value;
    wire [ROW_W-1:0]         o_out_row;
    wire [OCOL_W-1:0]        o_out_col;
    wire                     o_last_of_image;

    sliding_window_convolution_2d #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_coef_index    (i_coef_index),
        .i_coef_value    (i_coef_value),
        .i_pixel         (i_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_value         (o_value),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last_of_image (o_last_of_image)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_window_sum_board board;
    bit hold_req = 1'b0;   // asks the receiver for one long hold-off
    bit steady   = 1'b0;   // end of run: no idling on either side
    int stream_items = 0;

    // ------------------------------------------------------------------
    // Observer: everything is sampled as it stood just before the edge,
    // so the order of processes within the step does not matter.
    // Register writes, then input transfers, then result transfers.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : observe
        t_conv_result seen;
        if (i_rst_n) begin
            if (i_cfg_we) board.set_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                board.take_item(i_kind, i_coef_index, i_coef_value, i_pixel);
            if (o_out_valid && i_out_ready) begin
                seen.value = o_value;
                seen.row   = o_out_row;
                seen.col   = o_out_col;
                seen.last  = o_last_of_image;
                board.match_result(seen);
            end
        end
    end

    // Receiver: random bursts of refusal, ready stretches, one long hold-off
    initial begin : sink
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!steady && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: a run of cycles with no transfer at all means a hang
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers. Valid is only lowered ahead of an idle burst or a pause,
    // never in the step where the next item is raised.
    // ------------------------------------------------------------------
    task automatic offer_item(logic kind, logic [CIDX_W-1:0] cidx,
                              logic [COEF_W-1:0] cval, logic [PIX_W-1:0] pix);
        if (!steady && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_coef_index <= cidx;
        i_coef_value <= cval;
        i_pixel      <= pix;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // unused fields carry random bits so every bit toggles
    task automatic offer_coef(logic [CIDX_W-1:0] cidx, logic [COEF_W-1:0] cval);
        offer_item(KIND_COEF, cidx, cval, PIX_W'($urandom));
    endtask

    task automatic offer_pixel(logic [PIX_W-1:0] pix);
        offer_item(KIND_PIXEL, CIDX_W'($urandom), COEF_W'($urandom), pix);
    endtask

    // stop offering and wait until every expected result has come out,
    // then give coefficient and no-result pixels time to leave the pipe
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write enable stays up across back-to-back writes; regs_done lowers it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic regs_done();
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int i, j, n, mask, phase;
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 image, 3x3 kernel: exactly one sum, flagged as the last
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        write_reg(CFG_IMAGE_HEIGHT, 16'd3);
        write_reg(CFG_KERNEL_SIZE, 16'd3);
        regs_done();
        // whole kernel store written before any window reads it
        for (i = 0; i < KERNEL_TAPS; i++)
            offer_coef(CIDX_W'(i), (i == 0) ? 8'h80 :
                                   (i == KERNEL_TAPS - 1) ? 8'h7F : COEF_W'($urandom));
        // indices past the store are dropped
        offer_coef(CIDX_W'(KERNEL_TAPS), 8'h7F);
        offer_coef(5'h1F, 8'h80);
        for (i = 0; i < 9; i++) offer_pixel((i % 2) ? 8'h00 : 8'hFF);

        // kernel larger than a 2x2 image: nothing comes out, then the image wraps
        drain_results();
        write_reg(CFG_IMAGE_WIDTH, 16'd2);
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        regs_done();
        for (i = 0; i < 6; i++) offer_pixel(PIX_W'($urandom));

        // zero registers saturate to 1: each pixel is a whole 1x1 image
        drain_results();
        write_reg(CFG_IMAGE_WIDTH, 16'd0);
        write_reg(CFG_IMAGE_HEIGHT, 16'd0);
        write_reg(CFG_KERNEL_SIZE, 16'd0);
        regs_done();
        for (i = 0; i < 3; i++) offer_pixel(PIX_W'($urandom));

        // oversize kernel saturates to the full 5x5
        drain_results();
        write_reg(CFG_IMAGE_WIDTH, 16'd5);
        write_reg(CFG_IMAGE_HEIGHT, 16'd5);
        write_reg(CFG_KERNEL_SIZE, 16'd7);
        regs_done();
        for (i = 0; i < 25; i++) offer_pixel(PIX_W'($urandom));

        // all-ones width and height with a 1x1 kernel: a long first row
        drain_results();
        write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
        write_reg(CFG_KERNEL_SIZE, 16'd1);
        regs_done();
        for (i = 0; i < WIDE_PIXELS; i++) offer_pixel(PIX_W'($urandom));

        // random phases: small images, mostly pixels, coefficients mixed in
        phase = 0;
        while (stream_items < STREAM_TARGET) begin
            drain_results();
            if (phase == PRESSURE_PHASE) begin
                // plenty of results while the receiver holds off: input must stall
                write_reg(CFG_IMAGE_WIDTH, 16'd4);
                write_reg(CFG_IMAGE_HEIGHT, 16'd6);
                write_reg(CFG_KERNEL_SIZE, 16'd2);
                n = 48;
                hold_req = 1'b1;
            end else begin
                mask = $urandom_range(1, 7);
                if (mask[0])
                    write_reg(CFG_IMAGE_WIDTH, {5'($urandom),
                        ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 40))
                                                    : 11'($urandom_range(1, 10))});
                if (mask[1])
                    write_reg(CFG_IMAGE_HEIGHT,
                        ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
                                                    : 16'($urandom_range(1, 7)));
                if (mask[2])
                    write_reg(CFG_KERNEL_SIZE, {13'($urandom),
                        ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(1, 4))});
                n = $urandom_range(4, 80);
            end
            regs_done();
            for (j = 0; j < n; j++) begin
                if (phase == UNUSED_REG_PHASE && j == n / 2) begin
                    // sender pauses for every result; unused index must not restart
                    drain_results();
                    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
                    regs_done();
                end
                if ($urandom_range(0, 7) == 0)
                    offer_coef(CIDX_W'($urandom), COEF_W'($urandom));
                else
                    offer_pixel(PIX_W'($urandom));
                stream_items++;
                if (stream_items > STEADY_FROM) steady = 1'b1;
            end
            phase++;
        end

        drain_results();
        repeat (TAIL) @(posedge i_clk);
        board.close_out();
        if (board.faults == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
